>>> design/pdtc_pkg.sv
// ----------------------------------------------------------------------------
// pdtc_pkg: shared types and constants
// Beat types, command codes, register indexes and control bit positions
// for the periodic down timer with compare.
// ----------------------------------------------------------------------------
package pdtc_pkg;

    localparam int DATA_W          = 32;
    localparam int IDX_W           = 3;
    localparam int CTRL_W          = 26;
    localparam int PRESC_W         = 12;
    localparam int COUNT_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    localparam logic [IDX_W-1:0] REG_CONTROL = 3'd0;
    localparam logic [IDX_W-1:0] REG_STATUS  = 3'd1;
    localparam logic [IDX_W-1:0] REG_LOAD    = 3'd2;
    localparam logic [IDX_W-1:0] REG_COMPARE = 3'd3;
    localparam logic [IDX_W-1:0] REG_COUNT   = 3'd4;

    localparam int BIT_EN      = 0;
    localparam int BIT_ENMOD   = 1;
    localparam int BIT_OCIEN   = 2;
    localparam int BIT_RLD     = 3;
    localparam int PRESC_LSB   = 4;
    localparam int BIT_SWR     = 16;
    localparam int BIT_IOVW    = 17;
    localparam int CLKSRC_LSB  = 24;

    // soft reset keeps en, enmod, dbgen, waiten, dozen, stopen
    localparam logic [CTRL_W-1:0] SOFT_KEEP = 26'h03c0003;

    typedef struct packed {
        cmd_t              command;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_data;
    } in_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
        logic              compare_hit;
    } out_beat_t;

endpackage

>>> design/pdtc_core.sv
// ----------------------------------------------------------------------------
// pdtc_core: timer state and register file
// Holds control, flag, load, compare, count and prescaler state and works
// out one beat's register update and result in a single pass.
// ----------------------------------------------------------------------------
module pdtc_core #(
    parameter int COUNT_WIDTH = pdtc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_go,
    input  pdtc_pkg::in_beat_t  item,
    output pdtc_pkg::out_beat_t result
);

    logic [pdtc_pkg::CTRL_W-1:0]  ctrl_reg,  ctrl_next;
    logic                         flag_reg,  flag_next;
    logic [COUNT_WIDTH-1:0]       load_reg,  load_next;
    logic [COUNT_WIDTH-1:0]       cmp_reg,   cmp_next;
    logic [COUNT_WIDTH-1:0]       cnt_reg,   cnt_next;
    logic [pdtc_pkg::PRESC_W-1:0] presc_reg, presc_next;

    logic [pdtc_pkg::CTRL_W-1:0]  wr_ctrl;
    logic [pdtc_pkg::PRESC_W-1:0] presc_lim;
    logic [COUNT_WIDTH-1:0]       dec_val;
    logic [pdtc_pkg::DATA_W-1:0]  rd_val;
    logic                         hit;

    assign wr_ctrl   = item.write_data[pdtc_pkg::CTRL_W-1:0];
    assign presc_lim = ctrl_reg[pdtc_pkg::PRESC_LSB +: pdtc_pkg::PRESC_W];

    always_comb begin
        ctrl_next  = ctrl_reg;
        flag_next  = flag_reg;
        load_next  = load_reg;
        cmp_next   = cmp_reg;
        cnt_next   = cnt_reg;
        presc_next = presc_reg;
        rd_val     = '0;
        hit        = 1'b0;
        dec_val    = '0;
        case (item.command)
            pdtc_pkg::CMD_TICK: begin
                if (ctrl_reg[pdtc_pkg::BIT_EN] &&
                    (ctrl_reg[pdtc_pkg::CLKSRC_LSB +: 2] != 2'd0)) begin
                    if (presc_reg < presc_lim) begin
                        presc_next = presc_reg + 1'b1;
                    end else begin
                        presc_next = '0;
                        if (cnt_reg == '0) begin
                            dec_val = ctrl_reg[pdtc_pkg::BIT_RLD] ? load_reg : '1;
                        end else begin
                            dec_val = cnt_reg - 1'b1;
                        end
                        cnt_next = dec_val;
                        if (dec_val == cmp_reg) begin
                            flag_next = 1'b1;
                            hit       = 1'b1;
                        end
                    end
                end
            end
            pdtc_pkg::CMD_READ: begin
                unique case (item.reg_index)
                    pdtc_pkg::REG_CONTROL: rd_val = pdtc_pkg::DATA_W'(ctrl_reg);
                    pdtc_pkg::REG_STATUS:  rd_val = pdtc_pkg::DATA_W'(flag_reg);
                    pdtc_pkg::REG_LOAD:    rd_val = pdtc_pkg::DATA_W'(load_reg);
                    pdtc_pkg::REG_COMPARE: rd_val = pdtc_pkg::DATA_W'(cmp_reg);
                    pdtc_pkg::REG_COUNT:   rd_val = pdtc_pkg::DATA_W'(cnt_reg);
                    default:               rd_val = '0;
                endcase
            end
            pdtc_pkg::CMD_WRITE: begin
                unique case (item.reg_index)
                    pdtc_pkg::REG_CONTROL: begin
                        if (wr_ctrl[pdtc_pkg::BIT_SWR]) begin
                            ctrl_next  = wr_ctrl & pdtc_pkg::SOFT_KEEP;
                            flag_next  = 1'b0;
                            load_next  = '1;
                            cmp_next   = '0;
                            cnt_next   = '1;
                            presc_next = '0;
                        end else begin
                            ctrl_next = wr_ctrl;
                            // enable-mode load on a rising en
                            if (wr_ctrl[pdtc_pkg::BIT_EN] && !ctrl_reg[pdtc_pkg::BIT_EN] &&
                                wr_ctrl[pdtc_pkg::BIT_ENMOD]) begin
                                cnt_next   = wr_ctrl[pdtc_pkg::BIT_RLD] ? load_reg : '1;
                                presc_next = '0;
                            end
                        end
                    end
                    pdtc_pkg::REG_STATUS: begin
                        if (item.write_data[0]) begin
                            flag_next = 1'b0;
                        end
                    end
                    pdtc_pkg::REG_LOAD: begin
                        load_next = item.write_data[COUNT_WIDTH-1:0];
                        if (ctrl_reg[pdtc_pkg::BIT_IOVW]) begin
                            cnt_next = item.write_data[COUNT_WIDTH-1:0];
                        end
                    end
                    pdtc_pkg::REG_COMPARE: begin
                        cmp_next = item.write_data[COUNT_WIDTH-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.read_data   = rd_val;
        result.irq_level   = flag_next && ctrl_next[pdtc_pkg::BIT_OCIEN] &&
                             ctrl_next[pdtc_pkg::BIT_EN];
        result.compare_hit = hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg  <= '0;
            flag_reg  <= 1'b0;
            load_reg  <= '1;
            cmp_reg   <= '0;
            cnt_reg   <= '1;
            presc_reg <= '0;
        end else if (item_go) begin
            ctrl_reg  <= ctrl_next;
            flag_reg  <= flag_next;
            load_reg  <= load_next;
            cmp_reg   <= cmp_next;
            cnt_reg   <= cnt_next;
            presc_reg <= presc_next;
        end
    end

endmodule

>>> design/periodic_down_timer_compare_top.sv
// ----------------------------------------------------------------------------
// periodic_down_timer_compare_top: periodic down timer with compare
// Input register, single-pass timer core and result register.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one beat per tick, register read, register write or no-op
//   (command, reg_index, write_data), valid/ready handshake.
//   m_* channel: exactly one result beat per input beat, in order
//   (read_data, irq_level, compare_hit), valid/ready handshake.
//   A beat is registered in the input register, then in the result register.
//   Throughput is one beat per cycle while the receiver takes results, set
//   by the single-pass core update between the two registers.
//   On reset the timer registers take their reset values (load and count
//   all ones, everything else zero) and both pipeline registers empty.
//   When the receiver stalls, the result register holds its beat, the
//   input register still takes one more beat, then s_ready drops until
//   the result drains; timer state advances only when a beat moves on.
// ----------------------------------------------------------------------------
module periodic_down_timer_compare_top #(
    parameter int COUNT_WIDTH = pdtc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pdtc_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pdtc_pkg::out_beat_t m_data
);

    logic                in_vld_reg;
    pdtc_pkg::in_beat_t  in_data_reg;
    logic                out_vld_reg;
    pdtc_pkg::out_beat_t out_data_reg;
    pdtc_pkg::out_beat_t core_result;
    logic                advance;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    pdtc_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .item_go(advance),
        .item   (in_data_reg),
        .result (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

endmodule

>>> design/pdtc_checker.sv
// ----------------------------------------------------------------------------
// pdtc_checker: port-level checks
// Watches the top level's ports for reset, stall and result rules.
// ----------------------------------------------------------------------------
module pdtc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input pdtc_pkg::out_beat_t m_data
);

    // reset empties both stages
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("pipeline not empty after reset");

    // a compare hit only comes from a tick, which reads nothing
    a_hit_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.compare_hit |-> m_data.read_data == '0)
        else $error("compare hit with read data");

    // input back-pressure only while the result side stalls
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("s_ready low without output stall");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped under stall");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("m_data changed under stall");

endmodule

bind periodic_down_timer_compare_top pdtc_checker u_pdtc_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
